>>> hw/rtl/tsd_pkg.sv
`timescale 1ns / 1ps

package tsd_pkg;

  localparam int unsigned YearW   = 7;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned OutW    = 33;

  localparam int unsigned YearDays      = 365;
  localparam int unsigned DayHours      = 24;
  localparam int unsigned HourMinutes   = 60;
  localparam int unsigned MinuteSeconds = 60;
  localparam int unsigned YearMonths    = 12;

  typedef logic        [15:0] day_sum_t;
  typedef logic signed [16:0] day_num_t;
  typedef logic signed [17:0] day_diff_t;
  typedef logic signed [21:0] hour_t;
  typedef logic signed [27:0] minute_t;
  typedef logic signed [OutW-1:0] second_t;
  typedef logic signed [HourW:0] hour_diff_t;
  typedef logic signed [MinuteW:0] minute_diff_t;
  typedef logic signed [SecondW:0] second_diff_t;
  typedef logic        [8:0] month_days_t;

  localparam month_days_t MonthStart [YearMonths+1] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  function automatic month_days_t whole_month_days(logic [MonthW-1:0] month, logic leap);
    logic [3:0]  whole;
    month_days_t days;
    if (month == '0) begin
      whole = 4'd0;
    end else if (month > MonthW'(YearMonths)) begin
      whole = 4'(YearMonths);
    end else begin
      whole = 4'(month - MonthW'(1));
    end
    days = MonthStart[whole];
    if (leap && (whole >= 4'd2)) begin
      days = days + month_days_t'(1);
    end
    return days;
  endfunction

endpackage

>>> hw/rtl/tsd_day_count.sv
`timescale 1ns / 1ps

module tsd_day_count (
  input  logic [tsd_pkg::YearW-1:0]  year_i,
  input  logic [tsd_pkg::MonthW-1:0] month_i,
  input  logic [tsd_pkg::DayW-1:0]   day_i,
  output tsd_pkg::day_num_t          days_o
);
  import tsd_pkg::*;

  day_sum_t year_part;
  day_sum_t leap_part;
  day_sum_t total;
  logic     leap;

  assign leap      = (year_i[1:0] == 2'b00);
  assign year_part = day_sum_t'(year_i) * day_sum_t'(YearDays);
  assign leap_part = day_sum_t'((day_sum_t'(year_i) + day_sum_t'(3)) >> 2);
  assign total     = year_part + leap_part + day_sum_t'(whole_month_days(month_i, leap))
                   + day_sum_t'(day_i);
  assign days_o    = $signed({1'b0, total}) - day_num_t'(1);

endmodule

>>> hw/rtl/timestamp_second_difference.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   left_*_i, right_*_i timestamp pair
// out       output     out_valid_o / out_stall_i seconds_apart_o, left minus right
//
// Four register stages: day counts, hours, minutes, seconds.
// One pair is accepted every cycle while in_stall_o is low.
// Each stage holds its beat while the stage after it is full and stalled.
// Reset clears the stage valid bits only.
module timestamp_second_difference (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tsd_pkg::YearW-1:0]    left_year_i,
  input  logic [tsd_pkg::MonthW-1:0]   left_month_i,
  input  logic [tsd_pkg::DayW-1:0]     left_day_i,
  input  logic [tsd_pkg::HourW-1:0]    left_hour_i,
  input  logic [tsd_pkg::MinuteW-1:0]  left_minute_i,
  input  logic [tsd_pkg::SecondW-1:0]  left_second_i,
  input  logic [tsd_pkg::YearW-1:0]    right_year_i,
  input  logic [tsd_pkg::MonthW-1:0]   right_month_i,
  input  logic [tsd_pkg::DayW-1:0]     right_day_i,
  input  logic [tsd_pkg::HourW-1:0]    right_hour_i,
  input  logic [tsd_pkg::MinuteW-1:0]  right_minute_i,
  input  logic [tsd_pkg::SecondW-1:0]  right_second_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [tsd_pkg::OutW-1:0] seconds_apart_o
);
  import tsd_pkg::*;

  day_num_t     left_days;
  day_num_t     right_days;

  logic         v1_q, v2_q, v3_q, v4_q;
  logic         en1, en2, en3, en4;

  day_num_t     dl1_q, dr1_q;
  hour_diff_t   dh1_q;
  minute_diff_t dm1_q, dm2_q;
  second_diff_t ds1_q, ds2_q, ds3_q;
  hour_t        hrs2_d, hrs2_q;
  minute_t      min3_d, min3_q;
  second_t      sec4_d, sec4_q;
  day_diff_t    dd;

  tsd_day_count u_left_days (
    .year_i  (left_year_i),
    .month_i (left_month_i),
    .day_i   (left_day_i),
    .days_o  (left_days)
  );

  tsd_day_count u_right_days (
    .year_i  (right_year_i),
    .month_i (right_month_i),
    .day_i   (right_day_i),
    .days_o  (right_days)
  );

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  assign dd     = day_diff_t'(dl1_q) - day_diff_t'(dr1_q);
  assign hrs2_d = hour_t'(dd) * hour_t'(DayHours) + hour_t'(dh1_q);
  assign min3_d = minute_t'(hrs2_q) * minute_t'(HourMinutes) + minute_t'(dm2_q);
  assign sec4_d = second_t'(min3_q) * second_t'(MinuteSeconds) + second_t'(ds3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dl1_q <= left_days;
      dr1_q <= right_days;
      dh1_q <= $signed({1'b0, left_hour_i}) - $signed({1'b0, right_hour_i});
      dm1_q <= $signed({1'b0, left_minute_i}) - $signed({1'b0, right_minute_i});
      ds1_q <= $signed({1'b0, left_second_i}) - $signed({1'b0, right_second_i});
    end
    if (en2) begin
      hrs2_q <= hrs2_d;
      dm2_q  <= dm1_q;
      ds2_q  <= ds1_q;
    end
    if (en3) begin
      min3_q <= min3_d;
      ds3_q  <= ds2_q;
    end
    if (en4) begin
      sec4_q <= sec4_d;
    end
  end

  assign out_valid_o     = v4_q;
  assign seconds_apart_o = sec4_q;

endmodule

>>> tb/seconds_apart_checker.sv
`timescale 1ns / 1ps

module seconds_apart_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [tsd_pkg::YearW-1:0]       left_year_i,
  input  logic [tsd_pkg::MonthW-1:0]      left_month_i,
  input  logic [tsd_pkg::DayW-1:0]        left_day_i,
  input  logic [tsd_pkg::HourW-1:0]       left_hour_i,
  input  logic [tsd_pkg::MinuteW-1:0]     left_minute_i,
  input  logic [tsd_pkg::SecondW-1:0]     left_second_i,
  input  logic [tsd_pkg::YearW-1:0]       right_year_i,
  input  logic [tsd_pkg::MonthW-1:0]      right_month_i,
  input  logic [tsd_pkg::DayW-1:0]        right_day_i,
  input  logic [tsd_pkg::HourW-1:0]       right_hour_i,
  input  logic [tsd_pkg::MinuteW-1:0]     right_minute_i,
  input  logic [tsd_pkg::SecondW-1:0]     right_second_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic signed [tsd_pkg::OutW-1:0] seconds_apart_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              checked_o
);

  localparam int MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic signed [tsd_pkg::OutW-1:0] expected_gaps [$];
  logic signed [tsd_pkg::OutW-1:0] want;

  function automatic longint days_since_2000(logic [tsd_pkg::YearW-1:0] year,
                                             logic [tsd_pkg::MonthW-1:0] month,
                                             logic [tsd_pkg::DayW-1:0] day);
    longint days;
    int     whole;
    int     m;
    days  = longint'(year) * tsd_pkg::YearDays + (longint'(year) + 3) / 4;
    whole = (month == '0) ? 0 : int'(month) - 1;
    if (whole > tsd_pkg::YearMonths) begin
      whole = tsd_pkg::YearMonths;
    end
    for (m = 0; m < whole; m++) begin
      days += MonthLen[m];
      if (m == 1 && year[1:0] == 2'b00) begin
        days += 1;
      end
    end
    days += longint'(day) - 1;
    return days;
  endfunction

  function automatic logic signed [tsd_pkg::OutW-1:0] seconds_between();
    longint gap;
    gap = days_since_2000(left_year_i, left_month_i, left_day_i)
        - days_since_2000(right_year_i, right_month_i, right_day_i);
    gap = gap * tsd_pkg::DayHours + longint'(left_hour_i) - longint'(right_hour_i);
    gap = gap * tsd_pkg::HourMinutes + longint'(left_minute_i) - longint'(right_minute_i);
    gap = gap * tsd_pkg::MinuteSeconds + longint'(left_second_i) - longint'(right_second_i);
    return gap[tsd_pkg::OutW-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      errors_o  <= 0;
      checked_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_gaps.push_back(seconds_between());
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_gaps.size() == 0) begin
          $error("seconds_apart: no beat outstanding, actual %0d", seconds_apart_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_gaps.pop_front();
          if (want !== seconds_apart_i) begin
            $error("seconds_apart: expected %0d actual %0d", want, seconds_apart_i);
            errors_o <= errors_o + 1;
          end
          checked_o <= checked_o + 1;
        end
      end
    end
    pending_o <= expected_gaps.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [tsd_pkg::YearW-1:0]   year;
    logic [tsd_pkg::MonthW-1:0]  month;
    logic [tsd_pkg::DayW-1:0]    day;
    logic [tsd_pkg::HourW-1:0]   hour;
    logic [tsd_pkg::MinuteW-1:0] minute;
    logic [tsd_pkg::SecondW-1:0] second;
  } stamp_t;

  localparam int RandomPairs = 630;
  localparam int CalmTail    = 60;
  localparam int CycleLimit  = 200000;
  localparam int MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  logic signed [tsd_pkg::OutW-1:0] seconds_apart;
  stamp_t left_stamp;
  stamp_t right_stamp;

  int errors;
  int pending;
  int checked;
  int sent;
  int cycles;
  bit quiet;

  timestamp_second_difference dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .left_year_i     (left_stamp.year),
    .left_month_i    (left_stamp.month),
    .left_day_i      (left_stamp.day),
    .left_hour_i     (left_stamp.hour),
    .left_minute_i   (left_stamp.minute),
    .left_second_i   (left_stamp.second),
    .right_year_i    (right_stamp.year),
    .right_month_i   (right_stamp.month),
    .right_day_i     (right_stamp.day),
    .right_hour_i    (right_stamp.hour),
    .right_minute_i  (right_stamp.minute),
    .right_second_i  (right_stamp.second),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .seconds_apart_o (seconds_apart)
  );

  seconds_apart_checker checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .left_year_i     (left_stamp.year),
    .left_month_i    (left_stamp.month),
    .left_day_i      (left_stamp.day),
    .left_hour_i     (left_stamp.hour),
    .left_minute_i   (left_stamp.minute),
    .left_second_i   (left_stamp.second),
    .right_year_i    (right_stamp.year),
    .right_month_i   (right_stamp.month),
    .right_day_i     (right_stamp.day),
    .right_hour_i    (right_stamp.hour),
    .right_minute_i  (right_stamp.minute),
    .right_second_i  (right_stamp.second),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .seconds_apart_i (seconds_apart),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timestamp_second_difference: mismatch");
      $finish;
    end
  end

  function automatic stamp_t mk(int y, int mo, int d, int h, int mi, int s);
    stamp_t st;
    st.year   = y[tsd_pkg::YearW-1:0];
    st.month  = mo[tsd_pkg::MonthW-1:0];
    st.day    = d[tsd_pkg::DayW-1:0];
    st.hour   = h[tsd_pkg::HourW-1:0];
    st.minute = mi[tsd_pkg::MinuteW-1:0];
    st.second = s[tsd_pkg::SecondW-1:0];
    return st;
  endfunction

  function automatic stamp_t random_date();
    int y;
    int mo;
    int lim;
    y   = $urandom_range(0, 99);
    mo  = $urandom_range(1, 12);
    lim = MonthLen[mo-1] + ((mo == 2 && y % 4 == 0) ? 1 : 0);
    return mk(y, mo, $urandom_range(1, lim), $urandom_range(0, 23),
              $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  task automatic send_pair(input stamp_t l, input stamp_t r);
    in_valid    <= 1'b1;
    left_stamp  <= l;
    right_stamp <= r;
    do @(posedge clk); while (in_stall);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // The receiver stalls in bursts until the calm tail of the run.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    stamp_t l;
    stamp_t r;
    int     kind;
    int     mo;
    int     pick;
    sent        = 0;
    quiet       = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    left_stamp  <= '0;
    right_stamp <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(mk(0, 1, 1, 0, 0, 0), mk(0, 1, 1, 0, 0, 0));
    send_pair(mk(99, 12, 31, 23, 59, 59), mk(0, 1, 1, 0, 0, 0));
    send_pair(mk(0, 1, 1, 0, 0, 0), mk(99, 12, 31, 23, 59, 59));
    send_pair(mk(4, 2, 29, 12, 0, 0), mk(4, 3, 1, 12, 0, 0));
    send_pair(mk(5, 3, 1, 0, 0, 0), mk(5, 2, 28, 0, 0, 0));
    send_pair(mk(0, 3, 1, 0, 0, 0), mk(0, 2, 29, 0, 0, 0));
    send_pair(mk(10, 0, 15, 6, 30, 0), mk(10, 1, 15, 6, 30, 0));
    send_pair(mk(10, 13, 1, 0, 0, 0), mk(10, 15, 1, 0, 0, 0));
    send_pair(mk(20, 6, 0, 0, 0, 0), mk(20, 6, 1, 0, 0, 0));
    send_pair(mk(21, 2, 30, 0, 0, 0), mk(21, 3, 2, 0, 0, 0));
    send_pair(mk(1, 1, 1, 31, 63, 63), mk(1, 1, 1, 0, 0, 0));
    send_pair(mk(127, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0));
    send_pair(mk(0, 0, 0, 0, 0, 0), mk(127, 15, 31, 31, 63, 63));
    send_pair(mk(100, 1, 1, 0, 0, 0), mk(99, 1, 1, 0, 0, 0));
    send_pair(mk(3, 12, 31, 23, 59, 59), mk(4, 1, 1, 0, 0, 0));
    for (mo = 1; mo <= 12; mo += 2) begin
      send_pair(mk(8, mo, 1, 0, 0, 0), mk(9, mo + 1, 1, 0, 0, 0));
    end

    for (int i = 0; i < RandomPairs; i++) begin
      if (i == RandomPairs - CalmTail) begin
        quiet = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        l = stamp_t'({$urandom(), $urandom()});
        r = stamp_t'({$urandom(), $urandom()});
      end else if (kind < 40) begin
        l = random_date();
        r = l;
        pick = $urandom_range(0, 59);
        r.second = pick[tsd_pkg::SecondW-1:0];
        if (kind < 28) begin
          pick = $urandom_range(0, 23);
          r.hour = pick[tsd_pkg::HourW-1:0];
        end
      end else begin
        l = random_date();
        r = random_date();
      end
      send_pair(l, r);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d timestamp pairs, directed corners then random dates and raw bits;",
             sent);
    $display("%0d differences compared under random source gaps and receiver stalls.",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("timestamp_second_difference: match");
    end else begin
      $display("timestamp_second_difference: mismatch");
    end
    $finish;
  end

endmodule

>>> timestamp_second_difference.f
hw/rtl/tsd_pkg.sv
hw/rtl/tsd_day_count.sv
hw/rtl/timestamp_second_difference.sv
tb/seconds_apart_checker.sv
tb/testbench.sv
